// File: hw/rtl/b64sc_pkg.sv
// Shared types, character codes and alphabet functions for the base64 stream codec.
// No dependencies; imported by every module of the codec.
package b64sc_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int unsigned MAX_RES = 4;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       dv;
    logic       last;
    logic       err;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] left;
    logic       pad;
    logic       err;
  } codec_state_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [2:0]         count;
  } step_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return CHAR_UP_A + w;
    else if (v < 6'd52) return CHAR_LO_A + (w - 8'd26);
    else if (v < 6'd62) return CHAR_ZERO + (w - 8'd52);
    else if (v == 6'd62) return CHAR_PLUS;
    else                return CHAR_SLASH;
  endfunction

  // {valid, sextet}; valid low for a character outside the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d = c - CHAR_UP_A;
      return {1'b1, d[5:0]};
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d = c - CHAR_LO_A + 8'd26;
      return {1'b1, d[5:0]};
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO + 8'd52;
      return {1'b1, d[5:0]};
    end else if (c == CHAR_PLUS) begin
      return {1'b1, 6'd62};
    end else if (c == CHAR_SLASH) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

// File: hw/rtl/b64sc_step.sv
// Combinational encode/decode step: one item plus message state in, result burst
// and next state out. Depends on b64sc_pkg.
module b64sc_step (
  input  logic                  direction,
  input  b64sc_pkg::codec_state_t st,
  input  logic [7:0]            value,
  input  logic                  last,
  output b64sc_pkg::step_t      step,
  output b64sc_pkg::codec_state_t st_next
);
  import b64sc_pkg::*;

  logic [6:0] dec;
  logic [5:0] sx;
  logic       sx_ok;
  logic       is_pad;
  logic       have;
  logic [7:0] byte_v;
  logic       err_n;
  logic [2:0] n;

  always_comb begin
    step    = '0;
    st_next = st;
    dec     = char_to_sextet(value);
    is_pad  = (value == PAD_CHAR);
    sx      = is_pad ? 6'd0 : dec[5:0];
    sx_ok   = is_pad | dec[6];
    have    = 1'b0;
    byte_v  = 8'd0;
    err_n   = st.err;
    n       = 3'd0;

    if (direction == DIR_ENCODE) begin
      unique case (st.phase)
        2'd1: begin
          step.res[0].value = sextet_to_char({st.left[1:0], value[7:4]});
          st_next.left  = {2'b00, value[3:0]};
          st_next.phase = 2'd2;
          n = 3'd1;
          if (last) begin
            step.res[1].value = sextet_to_char({value[3:0], 2'b00});
            step.res[2].value = PAD_CHAR;
            n = 3'd3;
          end
        end
        2'd2: begin
          step.res[0].value = sextet_to_char({st.left[3:0], value[7:6]});
          step.res[1].value = sextet_to_char(value[5:0]);
          st_next.left  = 6'd0;
          st_next.phase = 2'd0;
          n = 3'd2;
        end
        default: begin
          // phase three cannot arise here; handled as a fresh group
          step.res[0].value = sextet_to_char(value[7:2]);
          st_next.left  = {4'b0000, value[1:0]};
          st_next.phase = 2'd1;
          n = 3'd1;
          if (last) begin
            step.res[1].value = sextet_to_char({value[1:0], 4'b0000});
            step.res[2].value = PAD_CHAR;
            step.res[3].value = PAD_CHAR;
            n = 3'd4;
          end
        end
      endcase
      for (int k = 0; k < MAX_RES; k++) begin
        step.res[k].dv   = (3'(k) < n);
        step.res[k].last = last && (3'(k) == n - 3'd1);
      end
      step.count = n;
      if (last) st_next = '0;
    end else begin
      if (is_pad) st_next.pad = 1'b1;
      if (!sx_ok || (!is_pad && st.pad)) err_n = 1'b1;
      st_next.err = err_n;
      if (sx_ok) begin
        unique case (st.phase)
          2'd0: begin
            st_next.left  = sx;
            st_next.phase = 2'd1;
          end
          2'd1: begin
            byte_v = {st.left, sx[5:4]};
            have   = 1'b1;
            st_next.left  = {2'b00, sx[3:0]};
            st_next.phase = 2'd2;
          end
          2'd2: begin
            byte_v = {st.left[3:0], sx[5:2]};
            have   = 1'b1;
            st_next.left  = {4'b0000, sx[1:0]};
            st_next.phase = 2'd3;
          end
          default: begin
            byte_v = {st.left[1:0], sx};
            have   = 1'b1;
            st_next.left  = 6'd0;
            st_next.phase = 2'd0;
          end
        endcase
        if (is_pad) have = 1'b0;
      end
      if (last) begin
        step.res[0].value = have ? byte_v : 8'd0;
        step.res[0].dv    = have;
        step.res[0].last  = 1'b1;
        step.res[0].err   = err_n;
        step.count        = 3'd1;
        st_next           = '0;
      end else begin
        step.res[0].value = byte_v;
        step.res[0].dv    = 1'b1;
        step.count        = have ? 3'd1 : 3'd0;
      end
    end
  end

endmodule

// File: hw/rtl/b64sc_burst.sv
// Result register: holds the burst of up to four results of one item and hands
// them out one per cycle while out_stall is low. Depends on b64sc_pkg.
module b64sc_burst (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  b64sc_pkg::step_t   step,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output b64sc_pkg::res_t    head
);
  import b64sc_pkg::*;

  res_t [MAX_RES-1:0] ents;
  logic [2:0]         rem;
  logic               take;

  assign out_valid = (rem != 3'd0);
  assign take      = out_valid && !out_stall;
  assign free      = (rem == 3'd0) || (rem == 3'd1 && take);
  assign head      = ents[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= step.count;
    end else if (take) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= step.res;
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        ents[k] <= ents[k+1];
      end
    end
  end

endmodule

// File: hw/rtl/base64_stream_codec_core.sv
// Base64 stream codec top level: input register, message state, step logic and
// result burst register. Depends on b64sc_pkg, b64sc_step and b64sc_burst.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | in_valid / in_stall     | in_value, in_last
//  output   | out_valid / out_stall   | out_value, data_valid, out_last, out_error
//  config   | direction_we            | direction_wdata
//
// A request is registered at acceptance and decoded from the input register into a
// burst of zero to four results, which loads into the result register when that is
// free. The result register hands out one result per cycle while out_stall is low.
// Most items give at most one result, an encoded byte that completes a group of
// three gives two, and a final encoded byte that leaves a partial group gives three
// or four. Reset clears direction and message state. A stall on the output holds
// the burst and backs up into in_stall.
module base64_stream_codec_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic       data_valid,
  output logic       out_last,
  output logic       out_error,
  input  logic       direction_we,
  input  logic       direction_wdata
);
  import b64sc_pkg::*;

  logic         direction;
  codec_state_t st;
  codec_state_t st_next;
  logic         s1_valid;
  logic [7:0]   s1_value;
  logic         s1_last;
  logic         s1_go;
  logic         in_take;
  logic         burst_free;
  step_t        step;
  res_t         head;

  assign s1_go    = s1_valid && burst_free;
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      st        <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (direction_we) begin
        direction <= direction_wdata;
        st        <= '0;
      end else if (s1_go) begin
        st <= st_next;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_value <= in_value;
      s1_last  <= in_last;
    end
  end

  b64sc_step u_step (
    .direction (direction),
    .st        (st),
    .value     (s1_value),
    .last      (s1_last),
    .step      (step),
    .st_next   (st_next)
  );

  b64sc_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go),
    .step      (step),
    .free      (burst_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_value  = head.value;
  assign data_valid = head.dv;
  assign out_last   = head.last;
  assign out_error  = head.err;

`ifndef SYNTHESIS
  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_error || out_last))
    else $error("error flag on a non-final result");

  a_enc_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction == DIR_ENCODE) |-> data_valid)
    else $error("empty result while encoding");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last && !direction_we) |=> (st == '0))
    else $error("message state not cleared after final item");

  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_take |-> (!s1_valid || s1_go))
    else $error("input register overwritten while held");
`endif

endmodule

// File: sim/base64_stream_codec_core_tb.sv
// Testbench for base64_stream_codec_core: directed and random encode/decode messages,
// checked against a built-in codec predictor. Depends on b64sc_pkg and the core RTL.
`timescale 1ns / 100ps

module base64_stream_codec_core_tb;
  import b64sc_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class codec_scoreboard;
    logic       dir;
    logic [1:0] grp;
    logic [5:0] held;
    logic       pad_flag;
    logic       bad_flag;
    res_t       pending_results[$];
    int         fails;
    int         checked;

    function new();
      dir     = DIR_ENCODE;
      fails   = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      grp      = 2'd0;
      held     = 6'd0;
      pad_flag = 1'b0;
      bad_flag = 1'b0;
    endfunction

    function void set_direction(logic d);
      dir = d;
      clear();
    endfunction

    function logic [7:0] to_char(logic [5:0] v);
      if (v < 6'd26) return CHAR_UP_A + 8'(v);
      if (v < 6'd52) return CHAR_LO_A + 8'(v) - 8'd26;
      if (v < 6'd62) return CHAR_ZERO + 8'(v) - 8'd52;
      return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // {ok, sextet}
    function logic [6:0] to_sextet(logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) d = c - CHAR_UP_A;
      else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) d = c - CHAR_LO_A + 8'd26;
      else if (c >= CHAR_ZERO && c <= CHAR_NINE) d = c - CHAR_ZERO + 8'd52;
      else if (c == CHAR_PLUS) d = 8'd62;
      else if (c == CHAR_SLASH) d = 8'd63;
      else return 7'd0;
      return {1'b1, d[5:0]};
    endfunction

    function res_t make_res(logic [7:0] v, logic dv, logic last, logic err);
      res_t r;
      r.value = v;
      r.dv    = dv;
      r.last  = last;
      r.err   = err;
      return r;
    endfunction

    function void note_request(logic [7:0] v, logic last);
      res_t       burst[$];
      logic [6:0] code;
      logic [5:0] s;
      logic [7:0] byte_out;
      logic       have;
      logic       ok;
      logic       is_pad;
      if (dir == DIR_ENCODE) begin
        case (grp)
          2'd1: begin
            burst.push_back(make_res(to_char({held[1:0], v[7:4]}), 1'b1, 1'b0, 1'b0));
            held = {2'b00, v[3:0]};
            grp  = 2'd2;
            if (last) begin
              burst.push_back(make_res(to_char({v[3:0], 2'b00}), 1'b1, 1'b0, 1'b0));
              burst.push_back(make_res(PAD_CHAR, 1'b1, 1'b0, 1'b0));
            end
          end
          2'd2: begin
            burst.push_back(make_res(to_char({held[3:0], v[7:6]}), 1'b1, 1'b0, 1'b0));
            burst.push_back(make_res(to_char(v[5:0]), 1'b1, 1'b0, 1'b0));
            held = 6'd0;
            grp  = 2'd0;
          end
          default: begin
            burst.push_back(make_res(to_char(v[7:2]), 1'b1, 1'b0, 1'b0));
            held = {4'b0000, v[1:0]};
            grp  = 2'd1;
            if (last) begin
              burst.push_back(make_res(to_char({v[1:0], 4'b0000}), 1'b1, 1'b0, 1'b0));
              burst.push_back(make_res(PAD_CHAR, 1'b1, 1'b0, 1'b0));
              burst.push_back(make_res(PAD_CHAR, 1'b1, 1'b0, 1'b0));
            end
          end
        endcase
        if (last) begin
          burst[burst.size()-1].last = 1'b1;
          clear();
        end
        foreach (burst[i]) pending_results.push_back(burst[i]);
      end else begin
        is_pad   = (v == PAD_CHAR);
        have     = 1'b0;
        byte_out = 8'd0;
        if (is_pad) begin
          s        = 6'd0;
          ok       = 1'b1;
          pad_flag = 1'b1;
        end else begin
          code = to_sextet(v);
          ok   = code[6];
          s    = code[5:0];
          if (ok && pad_flag) bad_flag = 1'b1;  // data after a pad still decodes
        end
        if (!ok) begin
          bad_flag = 1'b1;  // dropped, group does not advance
        end else begin
          case (grp)
            2'd0: begin
              held = s;
              grp  = 2'd1;
            end
            2'd1: begin
              byte_out = {held, s[5:4]};
              have     = 1'b1;
              held     = {2'b00, s[3:0]};
              grp      = 2'd2;
            end
            2'd2: begin
              byte_out = {held[3:0], s[5:2]};
              have     = 1'b1;
              held     = {4'b0000, s[1:0]};
              grp      = 2'd3;
            end
            default: begin
              byte_out = {held[1:0], s};
              have     = 1'b1;
              held     = 6'd0;
              grp      = 2'd0;
            end
          endcase
          if (is_pad) have = 1'b0;
        end
        if (!last) begin
          if (have) pending_results.push_back(make_res(byte_out, 1'b1, 1'b0, 1'b0));
        end else begin
          pending_results.push_back(make_res(have ? byte_out : 8'd0, have, 1'b1, bad_flag));
          clear();
        end
      end
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        fails++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_results.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, actual value=%h dv=%b last=%b err=%b",
                 $time, got.value, got.dv, got.last, got.err);
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      check_field("out_value", exp_r.value, got.value);
      check_field("data_valid", 8'(exp_r.dv), 8'(got.dv));
      check_field("out_last", 8'(exp_r.last), 8'(got.last));
      check_field("out_error", 8'(exp_r.err), 8'(got.err));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_value = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_value;
  logic       data_valid;
  logic       out_last;
  logic       out_error;
  logic       direction_we = 1'b0;
  logic       direction_wdata = 1'b0;

  codec_scoreboard sb = new();
  int          requests = 0;
  int          dir_writes = 0;
  int          burst_left = 0;
  int          stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  base64_stream_codec_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .data_valid     (data_valid),
    .out_last       (out_last),
    .out_error      (out_error),
    .direction_we   (direction_we),
    .direction_wdata(direction_wdata)
  );

  always #5 clk = ~clk;

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({out_value, data_valid, out_last, out_error});
    stall_tick++;
    if (stall_tick % 48 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall <= 1'($urandom_range(0, 1));
      default:     out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  task automatic send_item(input logic [7:0] v, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(v, last);
    requests++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // wait until every expected result is out, then let a message without
  // results finish in the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_idle();
    direction_we    <= 1'b1;
    direction_wdata <= d;
    @(posedge clk);
    direction_we <= 1'b0;
    sb.set_direction(d);
    dir_writes++;
  endtask

  task automatic run_phase(input logic d, input int target);
    logic [7:0] msg[$];
    int sent;
    int groups;
    int pads;
    int len;
    int kind;
    sent = 0;
    while (sent < target) begin
      msg.delete();
      if (d == DIR_ENCODE) begin
        len = $urandom_range(1, 7);
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        kind = $urandom_range(0, 3);
        if (kind != 0) begin
          // well-formed groups with random content, sometimes cut short
          groups = $urandom_range(1, 3);
          pads   = $urandom_range(0, 2);
          for (int i = 0; i < groups * 4; i++)
            msg.push_back(i >= groups * 4 - pads ? PAD_CHAR
                                                 : sb.to_char(6'($urandom_range(0, 63))));
          if (kind == 1 && msg.size() > 1) void'(msg.pop_back());
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            case ($urandom_range(0, 2))
              0:       msg.push_back(8'($urandom_range(0, 255)));
              1:       msg.push_back(PAD_CHAR);
              default: msg.push_back(sb.to_char(6'($urandom_range(0, 63))));
            endcase
          end
        end
      end
      send_message(msg);
      sent += msg.size();
    end
    // sometimes leave a message open; the next direction write must drop it
    if ($urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    logic [7:0] msg[$];
    logic       phase_dirs[6];
    phase_dirs = '{DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE, DIR_DECODE, DIR_ENCODE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode straight out of reset: one, two and three byte final groups
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'hFF, 8'hFE};
    send_message(msg);
    msg = '{8'h4D, 8'h61, 8'h6E};
    send_message(msg);

    write_direction(DIR_DECODE);
    send_text("+/9z");
    send_text("TQ==");
    send_text("*Q=B");  // invalid char, then data after a pad
    msg = '{8'hFF};     // lone invalid char: empty final with error
    send_message(msg);
    send_text("=");

    foreach (phase_dirs[p]) begin
      write_direction(phase_dirs[p]);
      run_phase(phase_dirs[p], 36);
    end

    wait_idle();
    $display("%0d requests sent over %0d direction writes, %0d results checked",
             requests, dir_writes, sb.checked);
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/b64sc_pkg.sv
hw/rtl/b64sc_step.sv
hw/rtl/b64sc_burst.sv
hw/rtl/base64_stream_codec_core.sv
sim/base64_stream_codec_core_tb.sv
